// File: rtl/bitmap_glyph_row_generator_defines.svh
// Assertion macros for the bitmap glyph row generator.
// Included by the top level; depends on nothing else.
`ifndef BITMAP_GLYPH_ROW_GENERATOR_DEFINES_SVH
`define BITMAP_GLYPH_ROW_GENERATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BGR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgr: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define BGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgr: next-cycle check failed");

`endif

// File: rtl/bgr_pkg.sv
// Shared types, constants and font tables of the bitmap glyph row generator.
// Used by every module of the block; depends on nothing.
package bgr_pkg;

   // Index of the bottom row and the row count below the baseline reference
   localparam logic [2:0]  LAST_ROW   = 3'd6;
   localparam logic [2:0]  BASE_ROWS  = 3'd7;

   // Largest coordinate on the 15-bit grid
   localparam logic [14:0] COORD_MAX  = 15'h3fff;

   // Advances in blocks
   localparam logic [2:0]  ADV_NARROW = 3'd4;
   localparam logic [2:0]  ADV_NORMAL = 3'd6;
   localparam logic [2:0]  ADV_WIDE   = 3'd7;

   // Reciprocal constants for divide-by-three
   localparam logic [11:0] RECIP3_BS    = 12'd43;   // x*43 >> 7 for x < 64
   localparam logic [17:0] RECIP3_SLANT = 18'd171;  // x*171 >> 9 for x < 512

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BLOCK_SIZE  = 2'd0,
      CSR_BOLD        = 2'd1,
      CSR_ITALIC      = 2'd2,
      CSR_FIXED_PITCH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [5:0] block_size;
      logic       bold_enable;
      logic       italic_enable;
      logic       fixed_pitch;
   } cfg_type;

   // Row 0 (top) is the leftmost element
   typedef logic [0:6][4:0] glyph_type;

   // One character, classified and ready for row expansion
   typedef struct packed {
      logic signed [14:0] pen;
      logic signed [14:0] pen_after;
      logic signed [13:0] baseline;
      glyph_type          glyph;
      logic [4:0]         bold_shift;
   } char_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Zero block size behaves as one
   function automatic logic [5:0] eff_block_size(input logic [5:0] bs);
      eff_block_size = (bs == 6'd0) ? 6'd1 : bs;
   endfunction

   // Fold a..z to A..Z
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7a) begin
         fold_case = c - 8'h20;
      end else begin
         fold_case = c;
      end
   endfunction

   // Advance in blocks for a folded code
   function automatic logic [2:0] advance_blocks(input logic [7:0] c, input logic fixed);
      if (fixed) begin
         advance_blocks = ADV_NORMAL;
      end else begin
         case (c) inside
            8'h49, 8'h31, 8'h2e, 8'h2c, 8'h3a, 8'h3b, 8'h27: advance_blocks = ADV_NARROW;
            8'h4d, 8'h57:                                   advance_blocks = ADV_WIDE;
            default:                                        advance_blocks = ADV_NORMAL;
         endcase
      end
   endfunction

   // Font ROM, top row first; unknown codes give the fallback glyph
   function automatic glyph_type font_glyph(input logic [7:0] c);
      case (c)
         8'h41: font_glyph = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}; // A
         8'h42: font_glyph = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e}; // B
         8'h43: font_glyph = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e}; // C
         8'h44: font_glyph = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e}; // D
         8'h45: font_glyph = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f}; // E
         8'h46: font_glyph = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10}; // F
         8'h47: font_glyph = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f}; // G
         8'h48: font_glyph = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}; // H
         8'h49: font_glyph = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e}; // I
         8'h4a: font_glyph = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c}; // J
         8'h4b: font_glyph = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
         8'h4c: font_glyph = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f}; // L
         8'h4d: font_glyph = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
         8'h4e: font_glyph = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
         8'h4f: font_glyph = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}; // O
         8'h50: font_glyph = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10}; // P
         8'h51: font_glyph = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d}; // Q
         8'h52: font_glyph = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11}; // R
         8'h53: font_glyph = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e}; // S
         8'h54: font_glyph = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
         8'h55: font_glyph = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}; // U
         8'h56: font_glyph = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h0a, 5'h04}; // V
         8'h57: font_glyph = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1b, 5'h11}; // W
         8'h58: font_glyph = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11}; // X
         8'h59: font_glyph = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
         8'h5a: font_glyph = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f}; // Z
         8'h30: font_glyph = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e}; // 0
         8'h31: font_glyph = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e}; // 1
         8'h32: font_glyph = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f}; // 2
         8'h33: font_glyph = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e}; // 3
         8'h34: font_glyph = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02}; // 4
         8'h35: font_glyph = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e}; // 5
         8'h36: font_glyph = {5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e}; // 6
         8'h37: font_glyph = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
         8'h38: font_glyph = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e}; // 8
         8'h39: font_glyph = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c}; // 9
         8'h2e: font_glyph = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c}; // period
         8'h2c: font_glyph = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h04, 5'h08}; // comma
         8'h2d: font_glyph = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00}; // minus
         8'h2b: font_glyph = {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00}; // plus
         8'h2f: font_glyph = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10}; // slash
         8'h3a: font_glyph = {5'h00, 5'h0c, 5'h0c, 5'h00, 5'h0c, 5'h0c, 5'h00}; // colon
         8'h3b: font_glyph = {5'h00, 5'h0c, 5'h0c, 5'h00, 5'h0c, 5'h04, 5'h08}; // semicolon
         8'h25: font_glyph = {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03}; // percent
         8'h27: font_glyph = {5'h0c, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00}; // apostrophe
         8'h22: font_glyph = {5'h0a, 5'h0a, 5'h14, 5'h00, 5'h00, 5'h00, 5'h00}; // quote
         8'h28: font_glyph = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02}; // open paren
         8'h29: font_glyph = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08}; // close paren
         8'h5b: font_glyph = {5'h0e, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0e}; // open bracket
         8'h5d: font_glyph = {5'h0e, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0e}; // close bracket
         8'h20: font_glyph = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}; // space
         default: font_glyph = {5'h1f, 5'h11, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04};
      endcase
   endfunction

endpackage

// File: rtl/bgr_req_if.sv
// Character request channel of the bitmap glyph row generator.
// Stand-alone valid/ready interface; depends on nothing.
interface bgr_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        char_code;
   logic              start_run;
   logic signed [13:0] run_origin_x;
   logic signed [13:0] baseline_pos;

   modport source (output valid, char_code, start_run, run_origin_x, baseline_pos,
                   input ready);
   modport sink   (input valid, char_code, start_run, run_origin_x, baseline_pos,
                   output ready);
endinterface

// File: rtl/bgr_rsp_if.sv
// Row result channel of the bitmap glyph row generator.
// Stand-alone valid/ready interface; depends on nothing.
interface bgr_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        row_number;
   logic signed [14:0] block_x;
   logic signed [14:0] block_y;
   logic [4:0]        dot_mask;
   logic [4:0]        bold_shift;
   logic signed [14:0] pen_after;
   logic              last_row;

   modport source (output valid, row_number, block_x, block_y, dot_mask, bold_shift,
                   pen_after, last_row, input ready);
   modport sink   (input valid, row_number, block_x, block_y, dot_mask, bold_shift,
                   pen_after, last_row, output ready);
endinterface

// File: rtl/bgr_front.sv
// Front end: accepts characters, looks up the glyph, tracks the pen.
// Depends on bgr_pkg and bgr_req_if; feeds bgr_queue.
module bgr_front (
   input  logic                  clock,
   input  logic                  reset,
   bgr_req_if.sink               req_chan,
   input  bgr_pkg::cfg_type      cfg,
   input  bgr_pkg::q_status_type q_status,
   output logic                  push_valid,
   output bgr_pkg::char_rec_type push_rec
);
   import bgr_pkg::*;

   logic signed [14:0] pen_ff;
   logic signed [14:0] pen_in;
   logic [7:0]         code_folded;
   logic [5:0]         bs;
   logic [2:0]         adv;
   logic [8:0]         step;
   logic signed [14:0] pen_now;
   logic [15:0]        pen_sum;
   logic [11:0]        bs_third_wide;
   logic [4:0]         bs_third;
   logic               accept;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && !q_status.full;

   // Classify the character and compute the advance
   always_comb begin
      code_folded   = fold_case(req_chan.char_code);
      bs            = eff_block_size(cfg.block_size);
      adv           = advance_blocks(code_folded, cfg.fixed_pitch);
      step          = {6'd0, adv} * {3'd0, bs};
      pen_now       = req_chan.start_run ? {req_chan.run_origin_x[13], req_chan.run_origin_x}
                                         : pen_ff;
      pen_sum       = {pen_now[14], pen_now} + {7'd0, step};
      bs_third_wide = {6'd0, bs} * RECIP3_BS;
      bs_third      = bs_third_wide[11:7];

      // Saturate the pen at the top of the grid; the advance is never negative
      if (!pen_sum[15] && pen_sum[14]) begin
         pen_in = COORD_MAX;
      end else begin
         pen_in = pen_sum[14:0];
      end

      push_valid           = accept;
      push_rec.pen         = pen_now;
      push_rec.pen_after   = pen_in;
      push_rec.baseline    = req_chan.baseline_pos;
      push_rec.glyph       = font_glyph(code_folded);
      if (cfg.bold_enable) begin
         push_rec.bold_shift = (bs_third == 5'd0) ? 5'd1 : bs_third;
      end else begin
         push_rec.bold_shift = 5'd0;
      end
   end

   // Advance the pen on every accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '0;
      end else if (accept) begin
         pen_ff <= pen_in;
      end
   end

endmodule

// File: rtl/bgr_queue.sv
// Short character queue between the front and back ends.
// Depends on bgr_pkg for the record type.
module bgr_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  bgr_pkg::char_rec_type push_rec,
   input  logic                  pop,
   output bgr_pkg::char_rec_type head_rec,
   output bgr_pkg::q_status_type q_status
);
   import bgr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   char_rec_type     rec_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_rec       = rec_ff[rd_ptr_ff];

   // Step pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the record; payload needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         rec_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// File: rtl/bgr_back.sv
// Back end: expands the head character into seven row items.
// Depends on bgr_pkg and bgr_rsp_if; drains bgr_queue.
module bgr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bgr_pkg::cfg_type      cfg,
   input  bgr_pkg::q_status_type q_status,
   input  bgr_pkg::char_rec_type head_rec,
   output logic                  pop,
   bgr_rsp_if.source             rsp_chan
);
   import bgr_pkg::*;

   // Row counter
   logic [2:0]         row_ff, row_in;

   // Stage A: row numerators
   logic               a_valid_ff, a_valid_in;
   logic [2:0]         a_row_ff;
   logic [8:0]         a_num_s_ff, a_num_s_in;
   logic [8:0]         a_num_y_ff, a_num_y_in;
   logic signed [14:0] a_pen_ff;
   logic signed [14:0] a_after_ff;
   logic signed [13:0] a_base_ff;
   logic [4:0]         a_mask_ff;
   logic [4:0]         a_bshift_ff;

   // Stage B: output register
   logic               b_valid_ff, b_valid_in;
   logic [2:0]         b_row_ff;
   logic [14:0]        b_x_ff, b_x_in;
   logic [14:0]        b_y_ff, b_y_in;
   logic [4:0]         b_mask_ff;
   logic [4:0]         b_bshift_ff;
   logic [14:0]        b_after_ff;

   logic               b_ready, a_ready, gen, a_load, b_load;
   logic [5:0]         bs;
   logic [17:0]        slant_wide;
   logic [7:0]         slant;
   logic [15:0]        x_sum;

   assign b_ready = !b_valid_ff || rsp_chan.ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign gen     = a_ready && !q_status.empty;
   assign pop     = gen && (row_ff == LAST_ROW);
   assign a_load  = gen;
   assign b_load  = b_ready && a_valid_ff;

   // Row numerators and handshake state
   always_comb begin
      bs         = eff_block_size(cfg.block_size);
      a_num_s_in = cfg.italic_enable ? {6'd0, LAST_ROW - row_ff} * {3'd0, bs} : 9'd0;
      a_num_y_in = {6'd0, BASE_ROWS - row_ff} * {3'd0, bs};
      row_in     = row_ff;
      if (gen) begin
         row_in = (row_ff == LAST_ROW) ? 3'd0 : row_ff + 3'd1;
      end
      a_valid_in = gen ? 1'b1 : (b_ready ? 1'b0 : a_valid_ff);
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   // Slant divide by three, then place the row
   always_comb begin
      slant_wide = {9'd0, a_num_s_ff} * RECIP3_SLANT;
      slant      = slant_wide[16:9];
      x_sum      = {a_pen_ff[14], a_pen_ff} + {8'd0, slant};
      if (!x_sum[15] && x_sum[14]) begin
         b_x_in = COORD_MAX;
      end else begin
         b_x_in = x_sum[14:0];
      end
      b_y_in = {a_base_ff[13], a_base_ff} - {6'd0, a_num_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Stage A payload
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_row_ff    <= row_ff;
         a_num_s_ff  <= a_num_s_in;
         a_num_y_ff  <= a_num_y_in;
         a_pen_ff    <= head_rec.pen;
         a_after_ff  <= head_rec.pen_after;
         a_base_ff   <= head_rec.baseline;
         a_mask_ff   <= head_rec.glyph[row_ff];
         a_bshift_ff <= head_rec.bold_shift;
      end
   end

   // Stage B payload; hold while the sink stalls
   always_ff @(posedge clock) begin
      if (b_load) begin
         b_row_ff    <= a_row_ff;
         b_x_ff      <= b_x_in;
         b_y_ff      <= b_y_in;
         b_mask_ff   <= a_mask_ff;
         b_bshift_ff <= a_bshift_ff;
         b_after_ff  <= a_after_ff;
      end
   end

   assign rsp_chan.valid      = b_valid_ff;
   assign rsp_chan.row_number = b_row_ff;
   assign rsp_chan.block_x    = b_x_ff;
   assign rsp_chan.block_y    = b_y_ff;
   assign rsp_chan.dot_mask   = b_mask_ff;
   assign rsp_chan.bold_shift = b_bshift_ff;
   assign rsp_chan.pen_after  = b_after_ff;
   assign rsp_chan.last_row   = (b_row_ff == LAST_ROW);

endmodule

// File: rtl/bitmap_glyph_row_generator.sv
// Top level of the bitmap glyph row generator: registers, front, queue, back.
// Depends on bgr_pkg, bgr_req_if, bgr_rsp_if, bgr_front, bgr_queue, bgr_back.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid/ready      char_code, start_run, run_origin_x, baseline_pos
//   rsp_chan  out        valid/ready      row_number, block_x, block_y, dot_mask,
//                                         bold_shift, pen_after, last_row
//   csr_*     in         csr_we, no wait  csr_index, csr_wdata
//
// Each character gives seven row items, one a cycle while the sink does not stall;
// the back end's row counter steps through the rows.
// A taken character is written into the queue, its first row is then loaded into
// stage A and then into stage B, which offers it on rsp_chan.
// The front takes a character whenever the queue of QUEUE_DEPTH entries has room.
// Reset is synchronous: pen to zero, registers to defaults, queue and pipe empty.
// A stalled sink holds the output register; the queue absorbs the front meanwhile.
`include "bitmap_glyph_row_generator_defines.svh"

module bitmap_glyph_row_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   bgr_req_if.sink                req_chan,
   bgr_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  bgr_pkg::csr_index_type csr_index,
   input  logic [5:0]             csr_wdata
);
   import bgr_pkg::*;

   cfg_type      cfg_ff;
   logic         push_valid;
   char_rec_type push_rec;
   char_rec_type head_rec;
   logic         pop;
   q_status_type q_status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size    <= 6'd1;
         cfg_ff.bold_enable   <= 1'b0;
         cfg_ff.italic_enable <= 1'b0;
         cfg_ff.fixed_pitch   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE:  cfg_ff.block_size    <= csr_wdata;
            CSR_BOLD:        cfg_ff.bold_enable   <= csr_wdata[0];
            CSR_ITALIC:      cfg_ff.italic_enable <= csr_wdata[0];
            CSR_FIXED_PITCH: cfg_ff.fixed_pitch   <= csr_wdata[0];
            default:         cfg_ff               <= cfg_ff;
         endcase
      end
   end

   bgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   bgr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .pop        (pop),
      .head_rec   (head_rec),
      .q_status   (q_status)
   );

   bgr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .head_rec (head_rec),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // A taken row that is not the last is followed at once by the next row
   `BGR_ASSERT_NEXT(a_rows_follow, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_row, rsp_chan.valid && (rsp_chan.row_number == $past(rsp_chan.row_number) + 3'd1))
   // A row item never shows a row past the bottom of the glyph
   `BGR_ASSERT_SAME(a_row_range, clock, reset, rsp_chan.valid, rsp_chan.row_number <= LAST_ROW)
   // The queue is never full and empty at once
   `BGR_ASSERT_SAME(a_queue_state, clock, reset, q_status.full, !q_status.empty)

endmodule
